### rtl/gdt_pkg.sv
// ----------------------------------------------------------------------------
// gdt_pkg
// Field widths, calendar constants and month tables shared by the date to
// tick converter and its channel interfaces.
// ----------------------------------------------------------------------------
package gdt_pkg;

   // Transaction field widths
   localparam int unsigned YEAR_W   = 14;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;
   localparam int unsigned MILLI_W  = 10;
   localparam int unsigned TICK_W   = 62;

   // Internal widths
   localparam int unsigned TPM_W    = 14;   // ticks per millisecond, up to 10000
   localparam int unsigned DOY_W    = 9;    // day of year, 0..365
   localparam int unsigned DAYS_W   = 23;   // day count, holds 16383 * 366
   localparam int unsigned TOD_W    = 27;   // millisecond of day
   localparam int unsigned MSUM_W   = 50;   // milliseconds since epoch

   localparam int unsigned TICKS_PER_MS_DEF = 10000;

   localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
   localparam logic [MONTH_W-1:0]  MONTH_JAN  = 4'd1;
   localparam logic [MONTH_W-1:0]  MONTH_FEB  = 4'd2;
   localparam logic [MONTH_W-1:0]  MONTH_DEC  = 4'd12;
   localparam logic [DAY_W-1:0]    FEB_LEAP_LEN = 5'd29;
   localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
   localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
   localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;
   localparam logic [MILLI_W-1:0]  MILLI_MAX  = 10'd999;

   localparam logic [8:0]  DAYS_PER_YEAR     = 9'd365;
   localparam logic [6:0]  YEARS_PER_CENTURY = 7'd100;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2**14
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 19;

   localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
   localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
   localparam logic [15:0] MS_PER_MIN  = 16'd60000;
   localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo);
      logic [DAY_W-1:0] len;
      case (mo)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] mo);
      logic [DOY_W-1:0] days;
      case (mo)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

### rtl/gdt_req_if.sv
// ----------------------------------------------------------------------------
// gdt_req_if
// Request channel: calendar date and time of day, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdt_req_if;
   import gdt_pkg::*;

   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   year_in;
   logic [MONTH_W-1:0]  month_in;
   logic [DAY_W-1:0]    day_in;
   logic [HOUR_W-1:0]   hour_in;
   logic [MINUTE_W-1:0] minute_in;
   logic [SECOND_W-1:0] second_in;
   logic [MILLI_W-1:0]  milli_in;

   modport source (
      output valid, year_in, month_in, day_in, hour_in, minute_in, second_in, milli_in,
      input  ready
   );

   modport sink (
      input  valid, year_in, month_in, day_in, hour_in, minute_in, second_in, milli_in,
      output ready
   );

endinterface

### rtl/gdt_rsp_if.sv
// ----------------------------------------------------------------------------
// gdt_rsp_if
// Response channel: tick count and invalid flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdt_rsp_if;
   import gdt_pkg::*;

   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] tick_count;
   logic              invalid;

   modport source (
      output valid, tick_count, invalid,
      input  ready
   );

   modport sink (
      input  valid, tick_count, invalid,
      output ready
   );

endinterface

### rtl/gregorian_date_to_ticks.sv
// A request transaction is accepted into the stage A register and passes through
// stages B to F; the response is driven from the stage F register.
// Throughput: one transaction per cycle; every stage holds on backpressure.
// Stage D holds the 23 x 27 bit day-to-millisecond multiply.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// gregorian_date_to_ticks
// Converts a proleptic Gregorian date and time of day into ticks since
// 0001-01-01 00:00:00.000, flagging out-of-range fields.
// ----------------------------------------------------------------------------
module gregorian_date_to_ticks #(
   parameter int unsigned TICKS_PER_MS = gdt_pkg::TICKS_PER_MS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gdt_req_if.sink   req_if,
   gdt_rsp_if.source rsp_if
);
   import gdt_pkg::*;

   localparam int unsigned NUM_STG = 6;
   localparam logic [TPM_W-1:0] TPM = TPM_W'(TICKS_PER_MS);

   // stage valids and per-stage advance
   logic [NUM_STG-1:0] vld_ff, vld_in, adv;

   always_comb begin
      adv[NUM_STG-1] = !vld_ff[NUM_STG-1] || rsp_if.ready;
      for (int k = NUM_STG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? req_if.valid : vld_ff[0];
      for (int k = 1; k < NUM_STG; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_if.ready = adv[0];

   // ---------------- stage A: captured fields
   logic [YEAR_W-1:0]   yr_a_ff;
   logic [MONTH_W-1:0]  mo_a_ff;
   logic [DAY_W-1:0]    dy_a_ff;
   logic [HOUR_W-1:0]   hr_a_ff;
   logic [MINUTE_W-1:0] mi_a_ff;
   logic [SECOND_W-1:0] se_a_ff;
   logic [MILLI_W-1:0]  ms_a_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         yr_a_ff <= req_if.year_in;
         mo_a_ff <= req_if.month_in;
         dy_a_ff <= req_if.day_in;
         hr_a_ff <= req_if.hour_in;
         mi_a_ff <= req_if.minute_in;
         se_a_ff <= req_if.second_in;
         ms_a_ff <= req_if.milli_in;
      end
   end

   // ---------------- stage B: centuries, field checks, time of day
   logic [YEAR_W-1:0] py_a;
   logic [26:0]       qy_prod, qpy_prod;
   logic [24:0]       qpy4_prod;
   logic              ok_a;
   logic [TOD_W-1:0]  tod_a;

   logic [YEAR_W-1:0]  yr_b_ff, py_b_ff;
   logic [MONTH_W-1:0] mo_b_ff;
   logic [DAY_W-1:0]   dy_b_ff;
   logic [7:0]         qy_b_ff, qpy_b_ff;
   logic [5:0]         qpy4_b_ff;
   logic               ok_b_ff;
   logic [TOD_W-1:0]   tod_b_ff;

   always_comb begin
      py_a      = yr_a_ff - YEAR_W'(1);
      qy_prod   = 27'(yr_a_ff) * 27'(RECIP_100);
      qpy_prod  = 27'(py_a) * 27'(RECIP_100);
      // floor(floor(py / 4) / 100) is floor(py / 400)
      qpy4_prod = 25'(py_a[YEAR_W-1:2]) * 25'(RECIP_100);
      ok_a = (yr_a_ff != '0) && (yr_a_ff <= YEAR_MAX)
          && (mo_a_ff >= MONTH_JAN) && (mo_a_ff <= MONTH_DEC)
          && (hr_a_ff <= HOUR_MAX) && (mi_a_ff <= MINUTE_MAX)
          && (se_a_ff <= SECOND_MAX) && (ms_a_ff <= MILLI_MAX);
      tod_a = TOD_W'(27'(hr_a_ff) * 27'(MS_PER_HOUR))
            + TOD_W'(27'(mi_a_ff) * 27'(MS_PER_MIN))
            + TOD_W'(27'(se_a_ff) * 27'(MS_PER_SEC))
            + TOD_W'(ms_a_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         yr_b_ff   <= yr_a_ff;
         py_b_ff   <= py_a;
         mo_b_ff   <= mo_a_ff;
         dy_b_ff   <= dy_a_ff;
         qy_b_ff   <= qy_prod[RECIP_SHIFT+7:RECIP_SHIFT];
         qpy_b_ff  <= qpy_prod[RECIP_SHIFT+7:RECIP_SHIFT];
         qpy4_b_ff <= qpy4_prod[RECIP_SHIFT+5:RECIP_SHIFT];
         ok_b_ff   <= ok_a;
         tod_b_ff  <= tod_a;
      end
   end

   // ---------------- stage C: leap rule, whole years, day of year, day check
   logic             leap_b;
   logic [DAY_W-1:0] len_b;
   logic [DAYS_W-1:0] days_y_b;
   logic [DOY_W-1:0]  doy_b;

   logic [DAYS_W-1:0] days_y_c_ff;
   logic [DOY_W-1:0]  doy_c_ff;
   logic              ok_c_ff;
   logic [TOD_W-1:0]  tod_c_ff;

   always_comb begin
      // divisible by 400 is divisible by 100 with a century count divisible by 4
      leap_b = (yr_b_ff[1:0] == 2'b00)
            && ((yr_b_ff != YEAR_W'(14'(qy_b_ff) * 14'(YEARS_PER_CENTURY)))
                || (qy_b_ff[1:0] == 2'b00));
      len_b  = (mo_b_ff == MONTH_FEB && leap_b) ? FEB_LEAP_LEN : month_len(mo_b_ff);
      days_y_b = DAYS_W'(23'(py_b_ff) * 23'(DAYS_PER_YEAR))
               + DAYS_W'(py_b_ff[YEAR_W-1:2])
               - DAYS_W'(qpy_b_ff)
               + DAYS_W'(qpy4_b_ff);
      doy_b = days_before_month(mo_b_ff)
            + DOY_W'((mo_b_ff > MONTH_FEB) && leap_b)
            + DOY_W'(dy_b_ff) - DOY_W'(1);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         days_y_c_ff <= days_y_b;
         doy_c_ff    <= doy_b;
         ok_c_ff     <= ok_b_ff && (dy_b_ff != '0) && (dy_b_ff <= len_b);
         tod_c_ff    <= tod_b_ff;
      end
   end

   // ---------------- stage D: days to milliseconds
   logic [DAYS_W-1:0] days_c;
   logic [MSUM_W-1:0] day_ms_d_ff;
   logic              ok_d_ff;
   logic [TOD_W-1:0]  tod_d_ff;

   assign days_c = days_y_c_ff + DAYS_W'(doy_c_ff);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         day_ms_d_ff <= MSUM_W'(days_c) * MSUM_W'(MS_PER_DAY);
         ok_d_ff     <= ok_c_ff;
         tod_d_ff    <= tod_c_ff;
      end
   end

   // ---------------- stage E: add time of day
   logic [MSUM_W-1:0] msum_e_ff;
   logic              ok_e_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         msum_e_ff <= day_ms_d_ff + MSUM_W'(tod_d_ff);
         ok_e_ff   <= ok_d_ff;
      end
   end

   // ---------------- stage F: scale to ticks, output register
   logic [63:0]       tick_prod;
   logic [TICK_W-1:0] tick_f_ff;
   logic              inv_f_ff;

   assign tick_prod = 64'(msum_e_ff) * 64'(TPM);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         tick_f_ff <= ok_e_ff ? tick_prod[TICK_W-1:0] : '0;
         inv_f_ff  <= !ok_e_ff;
      end
   end

   assign rsp_if.valid      = vld_ff[NUM_STG-1];
   assign rsp_if.tick_count = tick_f_ff;
   assign rsp_if.invalid    = inv_f_ff;

endmodule

### sim/gregorian_date_to_ticks_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_to_ticks_test
// Drives calendar dates through the date to tick converter under varying
// handshake pressure and checks every response transaction, field by field,
// against a behavioural tick calculation kept inside the bench, or against the typed table value.
// ----------------------------------------------------------------------------
module gregorian_date_to_ticks_test;
   import gdt_pkg::*;

   localparam int unsigned TICKS_PER_MS    = TICKS_PER_MS_DEF;
   localparam int unsigned CLOCK_PERIOD    = 12;
   localparam int unsigned TIMEOUT_CYCLES  = 400_000;
   localparam int unsigned SETTLE_CYCLES   = 20;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned ITEMS_PER_PHASE = 440;
   localparam int unsigned NUM_PHASES      = 4;
   localparam int unsigned NUM_DIRECTED    = 25;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [MILLI_W-1:0]  milli;
   } date_time_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick;
      logic              invalid;
   } tick_result_type;

   typedef struct packed {
      date_time_type   when;
      logic            typed;
      tick_result_type want;
   } directed_row_type;

   localparam int unsigned DAYS_IN_MONTH [13] =
      '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int unsigned DAYS_BEFORE [13] =
      '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   logic clock;
   logic reset;

   gdt_req_if req_ch ();
   gdt_rsp_if rsp_ch ();

   gregorian_date_to_ticks #(
      .TICKS_PER_MS (TICKS_PER_MS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   tick_result_type  expected_ticks [$];
   int unsigned      mismatches;
   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;
   int unsigned      hold_request;
   int unsigned      hold_left;
   logic             typed_check;
   tick_result_type  typed_result;
   directed_row_type directed_rows [NUM_DIRECTED];

   function automatic bit is_leap_year(input logic [YEAR_W-1:0] y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned month_length(input logic [YEAR_W-1:0] y,
                                                input logic [MONTH_W-1:0] m);
      if (m < 1 || m > 12)
         return 0;
      if (m == MONTH_FEB && is_leap_year(y))
         return 29;
      return DAYS_IN_MONTH[m];
   endfunction

   function automatic tick_result_type ticks_since_epoch(input date_time_type d);
      tick_result_type   r;
      longint unsigned   py;
      longint unsigned   days;
      longint unsigned   t;
      r.tick    = '0;
      r.invalid = 1'b1;
      if (d.year < 1 || d.year > 9999 || d.month < 1 || d.month > 12)
         return r;
      if (d.day < 1 || d.day > month_length(d.year, d.month))
         return r;
      if (d.hour > 23 || d.minute > 59 || d.second > 59 || d.milli > 999)
         return r;
      py   = d.year - 1;
      days = py * 365 + py / 4 - py / 100 + py / 400 + DAYS_BEFORE[d.month] + d.day - 1;
      if (d.month > MONTH_FEB && is_leap_year(d.year))
         days++;
      t = ((((days * 24 + d.hour) * 60 + d.minute) * 60 + d.second) * 1000 + d.milli)
          * TICKS_PER_MS;
      r.tick    = t[TICK_W-1:0];
      r.invalid = 1'b0;
      return r;
   endfunction

   // Called just after a falling edge; returns just after the falling edge that
   // follows the transaction.
   task automatic offer_date(input date_time_type d, input logic typed,
                             input tick_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.year_in   <= d.year;
      req_ch.month_in  <= d.month;
      req_ch.day_in    <= d.day;
      req_ch.hour_in   <= d.hour;
      req_ch.minute_in <= d.minute;
      req_ch.second_in <= d.second;
      req_ch.milli_in  <= d.milli;
      typed_check      <= typed;
      typed_result     <= want;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic await_all_ticks();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (expected_ticks.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2.0) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("gregorian_date_to_ticks: mismatch");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off when one is requested
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Records each request transaction and checks each response transaction
   always @(posedge clock) begin
      date_time_type   seen;
      tick_result_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen = '{req_ch.year_in, req_ch.month_in, req_ch.day_in, req_ch.hour_in,
                     req_ch.minute_in, req_ch.second_in, req_ch.milli_in};
            expected_ticks.push_back(typed_check ? typed_result : ticks_since_epoch(seen));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_ticks.size() == 0) begin
               $error("unexpected response: tick_count %0d invalid %0b",
                      rsp_ch.tick_count, rsp_ch.invalid);
               mismatches++;
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_ch.tick_count !== want.tick) begin
                  $error("tick_count: expected %0d, got %0d", want.tick, rsp_ch.tick_count);
                  mismatches++;
               end
               if (rsp_ch.invalid !== want.invalid) begin
                  $error("invalid: expected %0b, got %0b", want.invalid, rsp_ch.invalid);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      date_time_type d;
      int unsigned   pick;
      int unsigned   len;

      mismatches       = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_request     = 0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.year_in   = '0;
      req_ch.month_in  = '0;
      req_ch.day_in    = '0;
      req_ch.hour_in   = '0;
      req_ch.minute_in = '0;
      req_ch.second_in = '0;
      req_ch.milli_in  = '0;
      typed_check      = 1'b0;
      typed_result     = '0;

      //                year     mon    day    hour   min    sec    ms      typed  tick  inv
      directed_rows = '{
         '{'{14'd1,     4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b0}},
         '{'{14'd1,     4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  10'd1},   1'b1, '{62'd10000, 1'b0}},
         '{'{14'd9999,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999}, 1'b1,
           '{62'd3155378975999990000, 1'b0}},
         '{'{14'd0,     4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd10000, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 10'd1023}, 1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd0,  5'd1,  5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd13, 5'd1,  5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd15, 5'd1,  5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd1,  5'd0,  5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd4,  5'd31, 5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2023,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd1900,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2000,  4'd2,  5'd30, 5'd0,  6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd1,  5'd1,  5'd24, 6'd0,  6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd1,  5'd1,  5'd0,  6'd60, 6'd0,  10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd1,  5'd1,  5'd0,  6'd0,  6'd60, 10'd0},   1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  10'd1000}, 1'b1, '{62'd0, 1'b1}},
         '{'{14'd2024,  4'd2,  5'd29, 5'd12, 6'd30, 6'd30, 10'd500}, 1'b0, '{62'd0, 1'b0}},
         '{'{14'd2000,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  10'd0},   1'b0, '{62'd0, 1'b0}},
         '{'{14'd2024,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  10'd0},   1'b0, '{62'd0, 1'b0}},
         '{'{14'd2100,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  10'd0},   1'b0, '{62'd0, 1'b0}},
         '{'{14'd2023,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999}, 1'b0, '{62'd0, 1'b0}},
         '{'{14'd1,     4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999}, 1'b0, '{62'd0, 1'b0}},
         '{'{14'd9999,  4'd1,  5'd31, 5'd0,  6'd0,  6'd0,  10'd0},   1'b0, '{62'd0, 1'b0}}
      };

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_date(directed_rows[i].when, directed_rows[i].typed, directed_rows[i].want);
      await_all_ticks();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         // receiver stops dead while the sender keeps pushing, so the pipe backs up
         if (phase == 0)
            hold_request = HOLD_CYCLES;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(7))
               0:       d.year = 14'd1;
               1:       d.year = 14'd9999;
               2:       d.year = 14'(400 * $urandom_range(1, 24));
               3:       d.year = 14'(100 * $urandom_range(1, 99));
               4:       d.year = 14'(4 * $urandom_range(1, 2499));
               default: d.year = 14'($urandom_range(1, 9999));
            endcase
            d.month  = ($urandom_range(3) == 0) ? MONTH_FEB : 4'($urandom_range(1, 12));
            len      = month_length(d.year, d.month);
            d.day    = 5'($urandom_range(1, len));
            d.hour   = 5'($urandom_range(23));
            d.minute = 6'($urandom_range(59));
            d.second = 6'($urandom_range(59));
            d.milli  = 10'($urandom_range(999));

            pick = $urandom_range(99);
            if (pick < 10) begin
               // raw noise over the full field widths
               d.year   = 14'($urandom);
               d.month  = 4'($urandom);
               d.day    = 5'($urandom);
               d.hour   = 5'($urandom);
               d.minute = 6'($urandom);
               d.second = 6'($urandom);
               d.milli  = 10'($urandom);
            end else if (pick < 25) begin
               // one field pushed out of range, or Feb 29 of a century year
               case ($urandom_range(7))
                  0: d.year   = $urandom_range(1) ? 14'd0 : 14'($urandom_range(10000, 16383));
                  1: d.month  = $urandom_range(1) ? 4'd0 : 4'($urandom_range(13, 15));
                  2: d.day    = $urandom_range(1) ? 5'd0 : 5'($urandom_range(len + 1, 32));
                  3: d.hour   = 5'($urandom_range(24, 31));
                  4: d.minute = 6'($urandom_range(60, 63));
                  5: d.second = 6'($urandom_range(60, 63));
                  6: d.milli  = 10'($urandom_range(1000, 1023));
                  default: begin
                     d.year  = 14'(100 * $urandom_range(1, 99));
                     d.month = MONTH_FEB;
                     d.day   = FEB_LEAP_LEN;
                  end
               endcase
            end
            offer_date(d, 1'b0, '0);
         end
         await_all_ticks();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("gregorian_date_to_ticks: match");
      else
         $display("gregorian_date_to_ticks: mismatch");
      $finish;
   end

endmodule
